// ----- rtl/gdc_pkg.sv -----
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and constants for the grid ray caster
// Field widths, fixed-point constants, command and status codes, the
// register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package gdc_pkg;

  // Field widths
  localparam int unsigned POS_W  = 23;
  localparam int unsigned DIR_W  = 19;
  localparam int unsigned DIST_W = 31;
  localparam int unsigned CELL_W = 6;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned CFG_AW = 3;

  // Internal datapath widths
  localparam int unsigned COORD_W = 12;  // signed map coordinate during the walk
  localparam int unsigned CAM_W   = 28;  // signed camera offset, Q12.16
  localparam int unsigned RAY_W   = 32;  // signed ray component, Q16.16
  localparam int unsigned DIV_W   = 33;  // dividend and quotient width
  localparam int unsigned DVS_W   = 32;  // divisor width
  localparam int unsigned MA_W    = 19;  // multiplier operand a
  localparam int unsigned MB_W    = 32;  // multiplier operand b
  localparam int unsigned PROD_W  = MA_W + MB_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Default parameter values
  localparam int unsigned MAP_SIDE_DEF       = 64;
  localparam int unsigned SCREEN_COLUMNS_DEF = 640;
  localparam int unsigned STEP_LIMIT_DEF     = 128;

  // Commands
  localparam logic CMD_CAST  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PLANE_Y = 3'd5;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_CAM,
    S_MUL_RX,
    S_MUL_RY,
    S_RAY_Y,
    S_DIV_DX,
    S_DIV_DY,
    S_MUL_SX,
    S_MUL_SY,
    S_SET_SY,
    S_STEP,
    S_CHECK,
    S_OUT
  } state_e;

endpackage

// ----- rtl/gdc_ram.sv -----
// ----------------------------------------------------------------------------
// gdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/gdc_div.sv -----
// ----------------------------------------------------------------------------
// gdc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. A zero divisor yields an
// all-ones quotient.
// ----------------------------------------------------------------------------
module gdc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gdc_pkg::DIV_W-1:0] dividend_i,
  input  logic [gdc_pkg::DVS_W-1:0] divisor_i,
  output logic [gdc_pkg::DIV_W-1:0] quot_o,
  output gdc_pkg::div_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(gdc_pkg::DIV_W);

  logic                      busy_q, done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [gdc_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [gdc_pkg::DIV_W-1:0] quo_q;
  logic [gdc_pkg::DVS_W:0]   trial;
  logic                      fits;

  // Trial subtraction for the next quotient bit.
  always_comb begin
    trial = {rem_q, quo_q[gdc_pkg::DIV_W-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(gdc_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? gdc_pkg::DVS_W'(trial - {1'b0, dvs_q})
                    : trial[gdc_pkg::DVS_W-1:0];
      quo_q <= {quo_q[gdc_pkg::DIV_W-2:0], fits};
    end
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- rtl/grid_ray_dda_caster.sv -----
// ----------------------------------------------------------------------------
// grid_ray_dda_caster: DDA grid ray caster with a one-bit wall map
// A write result is valid in the cycle after the item is accepted. A cast
// runs a setup of three divider passes and six multiply and add steps,
// then walks the grid, each grid step passing a step and a check state.
// One item at a time; a new item is taken from the cycle after the result.
// After reset the whole map is swept clear, during which no item is
// accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster #(
  parameter int unsigned MAP_SIDE       = gdc_pkg::MAP_SIDE_DEF,
  parameter int unsigned SCREEN_COLUMNS = gdc_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned STEP_LIMIT     = gdc_pkg::STEP_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gdc_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [gdc_pkg::POS_W-1:0]  cfg_data_i,
  // Input items
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // column, cell_x, cell_y, wall
  input  logic                       s_axis_tuser,  // command
  // Result items
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [143:0]               m_axis_tdata,  // hit_x, hit_y, side, x_side_dist,
                                                    // y_side_dist, x_delta_dist,
                                                    // y_delta_dist
  output logic [1:0]                 m_axis_tuser   // status
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(STEP_LIMIT + 1);
  localparam int unsigned CW    = gdc_pkg::COORD_W;

  // Configuration registers
  logic [gdc_pkg::POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [gdc_pkg::DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 23'd131072;
      pos_y_q   <= 23'd131072;
      dir_x_q   <= 19'sd65536;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 19'sd43254;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        gdc_pkg::REG_POS_X:   pos_x_q   <= cfg_data_i;
        gdc_pkg::REG_POS_Y:   pos_y_q   <= cfg_data_i;
        gdc_pkg::REG_DIR_X:   dir_x_q   <= cfg_data_i[gdc_pkg::DIR_W-1:0];
        gdc_pkg::REG_DIR_Y:   dir_y_q   <= cfg_data_i[gdc_pkg::DIR_W-1:0];
        gdc_pkg::REG_PLANE_X: plane_x_q <= cfg_data_i[gdc_pkg::DIR_W-1:0];
        gdc_pkg::REG_PLANE_Y: plane_y_q <= cfg_data_i[gdc_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [gdc_pkg::COL_W-1:0]  in_column;
  logic [gdc_pkg::CELL_W-1:0] in_cell_x, in_cell_y;
  logic                       in_wall, in_accept;

  assign in_column = s_axis_tdata[9:0];
  assign in_cell_x = s_axis_tdata[15:10];
  assign in_cell_y = s_axis_tdata[21:16];
  assign in_wall   = s_axis_tdata[22];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Working registers
  gdc_pkg::state_e state_q, state_d;
  logic [AW-1:0]                    clr_q;
  logic signed [gdc_pkg::CAM_W-1:0] cam_q;
  logic signed [gdc_pkg::RAY_W-1:0] rx_q, ry_q;
  logic signed [gdc_pkg::PROD_W-1:0] prod_q;
  logic [gdc_pkg::DIST_W-1:0]       ddx_q, ddy_q, sdx_q, sdy_q;
  logic signed [CW-1:0]             mx_q, my_q;
  logic [NW-1:0]                    n_q;
  logic                             side_q;
  logic [1:0]                       status_q;

  // Shared divider
  logic                      div_start;
  logic [gdc_pkg::DIV_W-1:0] div_dividend, div_quot;
  logic [gdc_pkg::DVS_W-1:0] div_divisor, abs_rx, abs_ry;
  gdc_pkg::div_stat_t        div_stat;
  logic [gdc_pkg::DIST_W-1:0] delta_sat;

  assign abs_rx    = rx_q[gdc_pkg::RAY_W-1] ? gdc_pkg::DVS_W'(-rx_q) : gdc_pkg::DVS_W'(rx_q);
  assign abs_ry    = ry_q[gdc_pkg::RAY_W-1] ? gdc_pkg::DVS_W'(-ry_q) : gdc_pkg::DVS_W'(ry_q);
  assign delta_sat = (div_quot[gdc_pkg::DIV_W-1:gdc_pkg::DIST_W] != '0) ? gdc_pkg::DIST_MAX
                     : div_quot[gdc_pkg::DIST_W-1:0];

  gdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  // Shared multiplier, registered
  logic signed [gdc_pkg::MA_W-1:0] mul_a;
  logic signed [gdc_pkg::MB_W-1:0] mul_b;
  logic [16:0]                     frac_x, frac_y;
  logic [gdc_pkg::DIST_W-1:0]      side_sat;
  logic signed [gdc_pkg::RAY_W-1:0] prod_ray;

  assign frac_x = rx_q[gdc_pkg::RAY_W-1] ? {1'b0, pos_x_q[15:0]}
                                         : 17'd65536 - {1'b0, pos_x_q[15:0]};
  assign frac_y = ry_q[gdc_pkg::RAY_W-1] ? {1'b0, pos_y_q[15:0]}
                                         : 17'd65536 - {1'b0, pos_y_q[15:0]};
  assign side_sat = (prod_q[gdc_pkg::PROD_W-1:47] != '0) ? gdc_pkg::DIST_MAX : prod_q[46:16];
  assign prod_ray = prod_q[47:16];

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // One grid step
  logic                       take_x, out_map;
  logic signed [CW-1:0]       nmx, nmy;
  logic [gdc_pkg::DIST_W:0]   sum_x, sum_y;
  logic [gdc_pkg::DIST_W-1:0] nsdx, nsdy;

  always_comb begin
    take_x = sdx_q < sdy_q;
    sum_x  = {1'b0, sdx_q} + {1'b0, ddx_q};
    sum_y  = {1'b0, sdy_q} + {1'b0, ddy_q};
    nsdx   = sdx_q;
    nsdy   = sdy_q;
    nmx    = mx_q;
    nmy    = my_q;
    if (take_x) begin
      nsdx = sum_x[gdc_pkg::DIST_W] ? gdc_pkg::DIST_MAX : sum_x[gdc_pkg::DIST_W-1:0];
      nmx  = rx_q[gdc_pkg::RAY_W-1] ? mx_q - 1'b1 : mx_q + 1'b1;
    end else begin
      nsdy = sum_y[gdc_pkg::DIST_W] ? gdc_pkg::DIST_MAX : sum_y[gdc_pkg::DIST_W-1:0];
      nmy  = ry_q[gdc_pkg::RAY_W-1] ? my_q - 1'b1 : my_q + 1'b1;
    end
    out_map = nmx < 0 || nmy < 0 || nmx >= CW'(MAP_SIDE) || nmy >= CW'(MAP_SIDE);
  end

  // Wall map
  logic          ram_we, ram_wdata, ram_rdata, write_in_map;
  logic [AW-1:0] ram_waddr, ram_raddr;

  assign write_in_map = (32'(in_cell_x) < MAP_SIDE) && (32'(in_cell_y) < MAP_SIDE);
  assign ram_raddr    = AW'(32'(nmx[CW-2:0]) * MAP_SIDE + 32'(nmy[CW-2:0]));

  gdc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdc_pkg::S_CLEAR:   if (clr_q == AW'(DEPTH - 1)) state_d = gdc_pkg::S_IDLE;
      gdc_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser == gdc_pkg::CMD_WRITE) ? gdc_pkg::S_OUT
                                                         : gdc_pkg::S_DIV_CAM;
        end
      end
      gdc_pkg::S_DIV_CAM: if (div_stat.done) state_d = gdc_pkg::S_MUL_RX;
      gdc_pkg::S_MUL_RX:  state_d = gdc_pkg::S_MUL_RY;
      gdc_pkg::S_MUL_RY:  state_d = gdc_pkg::S_RAY_Y;
      gdc_pkg::S_RAY_Y:   state_d = gdc_pkg::S_DIV_DX;
      gdc_pkg::S_DIV_DX:  if (div_stat.done) state_d = gdc_pkg::S_DIV_DY;
      gdc_pkg::S_DIV_DY:  if (div_stat.done) state_d = gdc_pkg::S_MUL_SX;
      gdc_pkg::S_MUL_SX:  state_d = gdc_pkg::S_MUL_SY;
      gdc_pkg::S_MUL_SY:  state_d = gdc_pkg::S_SET_SY;
      gdc_pkg::S_SET_SY:  state_d = gdc_pkg::S_STEP;
      gdc_pkg::S_STEP:    state_d = out_map ? gdc_pkg::S_OUT : gdc_pkg::S_CHECK;
      gdc_pkg::S_CHECK: begin
        state_d = (ram_rdata || n_q == NW'(STEP_LIMIT)) ? gdc_pkg::S_OUT
                                                        : gdc_pkg::S_STEP;
      end
      gdc_pkg::S_OUT:     if (m_axis_tready) state_d = gdc_pkg::S_IDLE;
      default:            state_d = gdc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, unit operands and map port
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    div_dividend  = gdc_pkg::DIV_W'(64'd1 << 32);
    div_divisor   = abs_rx;
    mul_a         = plane_x_q;
    mul_b         = gdc_pkg::MB_W'(cam_q);
    ram_we        = 1'b0;
    ram_waddr     = clr_q;
    ram_wdata     = 1'b0;
    unique case (state_q)
      gdc_pkg::S_CLEAR: ram_we = 1'b1;
      gdc_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        div_dividend  = gdc_pkg::DIV_W'({in_column, 17'd0});
        div_divisor   = gdc_pkg::DVS_W'(SCREEN_COLUMNS);
        div_start     = in_accept && s_axis_tuser == gdc_pkg::CMD_CAST;
        ram_we        = in_accept && s_axis_tuser == gdc_pkg::CMD_WRITE && write_in_map;
        ram_waddr     = AW'(32'(in_cell_x) * MAP_SIDE + 32'(in_cell_y));
        ram_wdata     = in_wall;
      end
      gdc_pkg::S_MUL_RY: mul_a = plane_y_q;
      gdc_pkg::S_RAY_Y:  div_start = 1'b1;
      gdc_pkg::S_DIV_DX: begin
        div_divisor = abs_ry;
        div_start   = div_stat.done;
      end
      gdc_pkg::S_MUL_SX: begin
        mul_a = gdc_pkg::MA_W'($signed({2'b00, frac_x}));
        mul_b = $signed({1'b0, ddx_q});
      end
      gdc_pkg::S_MUL_SY: begin
        mul_a = gdc_pkg::MA_W'($signed({2'b00, frac_y}));
        mul_b = $signed({1'b0, ddy_q});
      end
      gdc_pkg::S_OUT: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // State and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdc_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == gdc_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gdc_pkg::S_IDLE: begin
        if (in_accept && s_axis_tuser == gdc_pkg::CMD_WRITE) begin
          status_q <= gdc_pkg::ST_WRITE;
          mx_q     <= CW'(in_cell_x);
          my_q     <= CW'(in_cell_y);
          side_q   <= 1'b0;
          sdx_q    <= '0;
          sdy_q    <= '0;
          ddx_q    <= '0;
          ddy_q    <= '0;
        end
      end
      gdc_pkg::S_DIV_CAM: begin
        if (div_stat.done) begin
          cam_q <= $signed(div_quot[gdc_pkg::CAM_W-1:0]) - gdc_pkg::CAM_W'(65536);
        end
      end
      gdc_pkg::S_MUL_RY: rx_q <= gdc_pkg::RAY_W'(dir_x_q) + prod_ray;
      gdc_pkg::S_RAY_Y:  ry_q <= gdc_pkg::RAY_W'(dir_y_q) + prod_ray;
      gdc_pkg::S_DIV_DX: if (div_stat.done) ddx_q <= delta_sat;
      gdc_pkg::S_DIV_DY: if (div_stat.done) ddy_q <= delta_sat;
      gdc_pkg::S_MUL_SY: sdx_q <= side_sat;
      gdc_pkg::S_SET_SY: begin
        sdy_q    <= side_sat;
        mx_q     <= CW'(pos_x_q[gdc_pkg::POS_W-1:16]);
        my_q     <= CW'(pos_y_q[gdc_pkg::POS_W-1:16]);
        n_q      <= '0;
        side_q   <= 1'b0;
        status_q <= gdc_pkg::ST_MISS;
      end
      gdc_pkg::S_STEP: begin
        sdx_q    <= nsdx;
        sdy_q    <= nsdy;
        mx_q     <= nmx;
        my_q     <= nmy;
        side_q   <= !take_x;
        n_q      <= n_q + 1'b1;
        status_q <= gdc_pkg::ST_MISS;
      end
      gdc_pkg::S_CHECK: status_q <= ram_rdata ? gdc_pkg::ST_HIT : gdc_pkg::ST_MISS;
      default: ;
    endcase
  end

  // Result item
  assign m_axis_tuser = status_q;
  assign m_axis_tdata = {7'd0, ddy_q, ddx_q, sdy_q, sdx_q, side_q,
                         my_q[gdc_pkg::CELL_W-1:0], mx_q[gdc_pkg::CELL_W-1:0]};

  // Assertions
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_accept |=> !s_axis_tready)
    else $error("item accepted while the previous one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tuser == gdc_pkg::ST_HIT || m_axis_tuser == gdc_pkg::ST_MISS
                         || m_axis_tuser == gdc_pkg::ST_WRITE))
    else $error("result status code out of range");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
      div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
